>>> hdl/wrse_pkg.sv
// ----------------------------------------------------------------------------
// wrse_pkg
// Shared types and constants for the wide register SIMD execute unit.
// ----------------------------------------------------------------------------
package wrse_pkg;

  localparam int WORD_BITS_DEF   = 32;
  localparam int NUM_SCALAR_DEF  = 32;
  localparam int NUM_WIDE_DEF    = 8;
  localparam int PC_BITS_DEF     = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int SCALAR_W        = 32;
  localparam int OUT_PC_W        = 16;

  typedef enum logic [4:0] {
    K_ADD   = 5'd0,  K_ADDI  = 5'd1,  K_ADDU  = 5'd2,  K_AND   = 5'd3,
    K_BEQ   = 5'd4,  K_BNE   = 5'd5,  K_J     = 5'd6,  K_JR    = 5'd7,
    K_LUW   = 5'd8,  K_NOT   = 5'd9,  K_OR    = 5'd10, K_SL    = 5'd11,
    K_SLV   = 5'd12, K_SR    = 5'd13, K_SRV   = 5'd14, K_SUB   = 5'd15,
    K_SUBU  = 5'd16, K_UWADD = 5'd17, K_UWAND = 5'd18, K_UWBEQ = 5'd19,
    K_UWBNE = 5'd20, K_UWCOM = 5'd21, K_UWEXP = 5'd22, K_UWLR  = 5'd23,
    K_UWNOT = 5'd24, K_UWOR  = 5'd25, K_UWSL  = 5'd26, K_UWSR  = 5'd27,
    K_UWSSQ = 5'd28, K_UWSUB = 5'd29
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_REG    = 3'd1,
    ST_ZERO_OFS   = 3'd2,
    ST_SHIFT_BIG  = 3'd3,
    ST_SAME_REG   = 3'd4,
    ST_BAD_STRIDE = 3'd5
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         dest;
    logic [5:0]         src_a;
    logic [5:0]         src_b;
    logic signed [15:0] imm;
    status_t            status;
  } op_t;

endpackage

>>> hdl/wrse_front.sv
// ----------------------------------------------------------------------------
// wrse_front
// Decodes an incoming instruction word and resolves its fault status.
// ----------------------------------------------------------------------------
module wrse_front #(
  parameter int WORD_BITS       = wrse_pkg::WORD_BITS_DEF,
  parameter int NUM_SCALAR_REGS = wrse_pkg::NUM_SCALAR_DEF,
  parameter int NUM_WIDE_REGS   = wrse_pkg::NUM_WIDE_DEF
) (
  input  logic [4:0]         kind,
  input  logic [5:0]         dest,
  input  logic [5:0]         src_a,
  input  logic [5:0]         src_b,
  input  logic signed [15:0] imm,
  output wrse_pkg::op_t      op
);

  localparam int ROW_W = WORD_BITS * WORD_BITS;

  wrse_pkg::kind_t   kd;
  wrse_pkg::status_t st;
  logic              sd, sa, sb, wd, wa, wb;
  logic [15:0]       iraw;

  assign kd   = wrse_pkg::kind_t'(kind);
  assign iraw = imm;
  assign sd   = int'(dest)  < NUM_SCALAR_REGS;
  assign sa   = int'(src_a) < NUM_SCALAR_REGS;
  assign sb   = int'(src_b) < NUM_SCALAR_REGS;
  assign wd   = int'(dest)  < NUM_WIDE_REGS;
  assign wa   = int'(src_a) < NUM_WIDE_REGS;
  assign wb   = int'(src_b) < NUM_WIDE_REGS;

  // register checks first, then operand checks
  always_comb begin
    st = wrse_pkg::ST_OK;
    unique case (kd) inside
      wrse_pkg::K_ADD, wrse_pkg::K_ADDU, wrse_pkg::K_SUB, wrse_pkg::K_SUBU,
      wrse_pkg::K_AND, wrse_pkg::K_OR, wrse_pkg::K_SLV, wrse_pkg::K_SRV: begin
        if (!(sd && sa && sb)) st = wrse_pkg::ST_BAD_REG;
      end
      wrse_pkg::K_ADDI, wrse_pkg::K_NOT: begin
        if (!(sd && sa)) st = wrse_pkg::ST_BAD_REG;
      end
      wrse_pkg::K_BEQ, wrse_pkg::K_BNE: begin
        if (!(sa && sb)) st = wrse_pkg::ST_BAD_REG;
        else if (iraw == '0) st = wrse_pkg::ST_ZERO_OFS;
      end
      wrse_pkg::K_J: begin
        st = wrse_pkg::ST_OK;
      end
      wrse_pkg::K_JR: begin
        if (!sa) st = wrse_pkg::ST_BAD_REG;
      end
      wrse_pkg::K_LUW: begin
        if (!(sd && wa)) st = wrse_pkg::ST_BAD_REG;
      end
      wrse_pkg::K_SL, wrse_pkg::K_SR: begin
        if (!(sd && sa)) st = wrse_pkg::ST_BAD_REG;
        else if (32'(iraw) >= WORD_BITS) st = wrse_pkg::ST_SHIFT_BIG;
      end
      wrse_pkg::K_UWADD, wrse_pkg::K_UWAND, wrse_pkg::K_UWOR, wrse_pkg::K_UWSUB: begin
        if (!(wd && wa && wb)) st = wrse_pkg::ST_BAD_REG;
      end
      wrse_pkg::K_UWNOT: begin
        if (!(wd && wa)) st = wrse_pkg::ST_BAD_REG;
      end
      wrse_pkg::K_UWBEQ, wrse_pkg::K_UWBNE: begin
        if (!(wa && wb)) st = wrse_pkg::ST_BAD_REG;
        else if (iraw == '0) st = wrse_pkg::ST_ZERO_OFS;
      end
      wrse_pkg::K_UWCOM, wrse_pkg::K_UWEXP: begin
        if (!(wd && wa)) st = wrse_pkg::ST_BAD_REG;
        else if (dest == src_a) st = wrse_pkg::ST_SAME_REG;
      end
      wrse_pkg::K_UWLR: begin
        if (!(wd && sa)) st = wrse_pkg::ST_BAD_REG;
      end
      wrse_pkg::K_UWSL, wrse_pkg::K_UWSR: begin
        if (!(wd && wa)) st = wrse_pkg::ST_BAD_REG;
        else if (32'(iraw) >= ROW_W) st = wrse_pkg::ST_SHIFT_BIG;
      end
      wrse_pkg::K_UWSSQ: begin
        if (!wd) st = wrse_pkg::ST_BAD_REG;
        else if (iraw != 16'd0 && iraw != 16'd1 && iraw != 16'd2 && iraw != 16'd4 &&
                 iraw != 16'd8 && iraw != 16'd16 && iraw != 16'd32)
          st = wrse_pkg::ST_BAD_STRIDE;
      end
      default: st = wrse_pkg::ST_OK;
    endcase
  end

  always_comb begin
    op.kind   = kd;
    op.dest   = dest;
    op.src_a  = src_a;
    op.src_b  = src_b;
    op.imm    = imm;
    op.status = st;
  end

endmodule

>>> hdl/wrse_queue.sv
// ----------------------------------------------------------------------------
// wrse_queue
// Short FIFO of decoded instructions between decode and execute.
// ----------------------------------------------------------------------------
module wrse_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wrse_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output wrse_pkg::op_t head_op
);

  localparam int DEPTH = wrse_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wrse_pkg::op_t    ent_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign head_op   = ent_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_op;
  end

endmodule

>>> hdl/wrse_back.sv
// ----------------------------------------------------------------------------
// wrse_back
// Register files, program counter and execute stage with result register.
// ----------------------------------------------------------------------------
module wrse_back #(
  parameter int WORD_BITS       = wrse_pkg::WORD_BITS_DEF,
  parameter int NUM_SCALAR_REGS = wrse_pkg::NUM_SCALAR_DEF,
  parameter int NUM_WIDE_REGS   = wrse_pkg::NUM_WIDE_DEF,
  parameter int PC_BITS         = wrse_pkg::PC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  wrse_pkg::op_t        q_op,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [15:0]          out_next_pc,
  output logic                 out_branch_taken,
  output logic                 out_overflow,
  output logic signed [31:0]   out_scalar_value
);

  localparam int WB    = WORD_BITS;
  localparam int ROW_W = WB * WB;
  localparam int SI    = $clog2(NUM_SCALAR_REGS);
  localparam int WI    = $clog2(NUM_WIDE_REGS);
  localparam int SH_W  = $clog2(ROW_W);
  localparam int SW    = wrse_pkg::SCALAR_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } bstate_t;

  bstate_t           st_r;
  logic [SW-1:0]     s_mem [NUM_SCALAR_REGS];
  logic [NUM_SCALAR_REGS-1:0] s_vld_r;
  logic [ROW_W-1:0]  w_mem [NUM_WIDE_REGS];
  logic [NUM_WIDE_REGS-1:0]   w_vld_r;

  wrse_pkg::op_t     ex_r;
  logic [SW-1:0]     sx_r, sy_r;
  logic [ROW_W-1:0]  wa_r, wb_r;
  logic [PC_BITS-1:0] pc_r;
  logic              ovf_r;

  logic              out_valid_r, out_taken_r, out_ovf_r;
  logic [2:0]        out_status_r;
  logic [15:0]       out_npc_r;
  logic [SW-1:0]     out_val_r;

  logic [SI-1:0]     rsa, rsb, sd_i;
  logic [WI-1:0]     rwa, rwb, wd_i;
  logic              exec, ok;
  logic [15:0]       iraw;
  logic [SW-1:0]     imm32, res;
  logic [PC_BITS-1:0] imm_pc, pc_inc, npc;
  logic              taken, swr, wwr, ovf_set, part;
  logic [ROW_W-1:0]  wdata;
  logic [WB-1:0]     wmask, comv, base;
  logic [2:0]        st_lg;
  logic              st_zero;

  assign rsa  = q_op.src_a[SI-1:0];
  assign rsb  = q_op.src_b[SI-1:0];
  assign rwa  = (q_op.kind == wrse_pkg::K_UWSSQ) ? q_op.dest[WI-1:0] : q_op.src_a[WI-1:0];
  assign rwb  = q_op.src_b[WI-1:0];
  assign sd_i = ex_r.dest[SI-1:0];
  assign wd_i = ex_r.dest[WI-1:0];

  // take the next word only when the result register will be free
  assign q_pop = (st_r == S_IDLE) && q_not_empty && (!out_valid_r || !out_stall);
  assign exec  = (st_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_r <= q_op;
      sx_r <= s_vld_r[rsa] ? s_mem[rsa] : '0;
      sy_r <= s_vld_r[rsb] ? s_mem[rsb] : '0;
      wa_r <= w_vld_r[rwa] ? w_mem[rwa] : '0;
      wb_r <= w_vld_r[rwb] ? w_mem[rwb] : '0;
    end
  end

  assign ok     = ex_r.status == wrse_pkg::ST_OK;
  assign iraw   = ex_r.imm;
  assign imm32  = {{(SW - 16){ex_r.imm[15]}}, ex_r.imm};
  assign imm_pc = PC_BITS'(imm32);
  assign pc_inc = pc_r + 1'b1;
  assign base   = wa_r[ROW_W-1 -: WB];

  always_comb begin
    st_zero = 1'b0;
    st_lg   = 3'd0;
    case (iraw[5:0])
      6'd1:    st_lg = 3'd0;
      6'd2:    st_lg = 3'd1;
      6'd4:    st_lg = 3'd2;
      6'd8:    st_lg = 3'd3;
      6'd16:   st_lg = 3'd4;
      6'd32:   st_lg = 3'd5;
      default: st_zero = 1'b1;
    endcase
  end

  always_comb begin
    npc     = pc_inc;
    taken   = 1'b0;
    res     = '0;
    swr     = 1'b0;
    wwr     = 1'b0;
    part    = 1'b0;
    ovf_set = 1'b0;
    wdata   = '0;
    comv    = '0;
    unique case (ex_r.kind) inside
      wrse_pkg::K_ADD: begin
        res = sx_r + sy_r; swr = 1'b1;
        ovf_set = (~(sx_r ^ sy_r) & (sx_r ^ res)) >> (SW - 1) != '0;
      end
      wrse_pkg::K_ADDU: begin res = sx_r + sy_r; swr = 1'b1; end
      wrse_pkg::K_ADDI: begin
        res = sx_r + imm32; swr = 1'b1;
        ovf_set = (~(sx_r ^ imm32) & (sx_r ^ res)) >> (SW - 1) != '0;
      end
      wrse_pkg::K_SUB: begin
        res = sx_r - sy_r; swr = 1'b1;
        ovf_set = ((sx_r ^ sy_r) & (sx_r ^ res)) >> (SW - 1) != '0;
      end
      wrse_pkg::K_SUBU: begin res = sx_r - sy_r; swr = 1'b1; end
      wrse_pkg::K_AND:  begin res = sx_r & sy_r; swr = 1'b1; end
      wrse_pkg::K_OR:   begin res = sx_r | sy_r; swr = 1'b1; end
      wrse_pkg::K_NOT:  begin res = ~sx_r; swr = 1'b1; end
      wrse_pkg::K_SL:   begin res = sx_r << iraw[4:0]; swr = 1'b1; end
      wrse_pkg::K_SR:   begin res = SW'($signed(sx_r) >>> iraw[4:0]); swr = 1'b1; end
      wrse_pkg::K_SLV:  begin res = sx_r << sy_r[4:0]; swr = 1'b1; end
      wrse_pkg::K_SRV:  begin res = SW'($signed(sx_r) >>> sy_r[4:0]); swr = 1'b1; end
      wrse_pkg::K_LUW:  begin res = SW'(base); swr = 1'b1; end
      wrse_pkg::K_BEQ, wrse_pkg::K_BNE: begin
        if ((sx_r == sy_r) == (ex_r.kind == wrse_pkg::K_BEQ)) begin
          npc = pc_r + imm_pc; taken = 1'b1;
        end
      end
      wrse_pkg::K_J:  begin npc = imm_pc; taken = 1'b1; end
      wrse_pkg::K_JR: begin npc = PC_BITS'(sx_r); taken = 1'b1; end
      wrse_pkg::K_UWBEQ, wrse_pkg::K_UWBNE: begin
        if ((wa_r == wb_r) == (ex_r.kind == wrse_pkg::K_UWBEQ)) begin
          npc = pc_r + imm_pc; taken = 1'b1;
        end
      end
      wrse_pkg::K_UWADD: begin
        wwr = 1'b1;
        for (int i = 0; i < WB; i++) wdata[i*WB +: WB] = wa_r[i*WB +: WB] + wb_r[i*WB +: WB];
      end
      wrse_pkg::K_UWSUB: begin
        wwr = 1'b1;
        for (int i = 0; i < WB; i++) wdata[i*WB +: WB] = wa_r[i*WB +: WB] - wb_r[i*WB +: WB];
      end
      wrse_pkg::K_UWAND: begin wwr = 1'b1; wdata = wa_r & wb_r; end
      wrse_pkg::K_UWOR:  begin wwr = 1'b1; wdata = wa_r | wb_r; end
      wrse_pkg::K_UWNOT: begin wwr = 1'b1; wdata = ~wa_r; end
      wrse_pkg::K_UWCOM: begin
        // gather block top bits, block 0 lands in the msb
        for (int i = 0; i < WB; i++) comv[WB-1-i] = wa_r[(WB-1-i)*WB + WB - 1];
        wwr = 1'b1; part = 1'b1;
        wdata[ROW_W-1 -: WB] = comv;
      end
      wrse_pkg::K_UWEXP: begin
        wwr = 1'b1;
        for (int i = 0; i < WB; i++) wdata[(WB-1-i)*WB + WB - 1] = base[WB-1-i];
      end
      wrse_pkg::K_UWLR: begin
        wwr = 1'b1; part = 1'b1;
        wdata[ROW_W-1 -: WB] = WB'(sx_r);
      end
      wrse_pkg::K_UWSL: begin wwr = 1'b1; wdata = wa_r << iraw[SH_W-1:0]; end
      wrse_pkg::K_UWSR: begin wwr = 1'b1; wdata = wa_r >> iraw[SH_W-1:0]; end
      wrse_pkg::K_UWSSQ: begin
        wwr = 1'b1;
        for (int i = 0; i < WB; i++)
          wdata[(WB-1-i)*WB +: WB] = base + (st_zero ? '0 : (WB'(i) << st_lg));
      end
      default: begin
        res = '0;
      end
    endcase
    // a faulted word changes nothing and steps the counter by one
    if (!ok) begin
      npc = pc_inc; taken = 1'b0; res = '0;
      swr = 1'b0; wwr = 1'b0; ovf_set = 1'b0;
    end
    if (!swr) res = '0;
  end

  // partial writes of a never-written row must zero the rest of it
  assign wmask = (part && w_vld_r[wd_i]) ? {1'b1, {(WB - 1){1'b0}}} : '1;

  always_ff @(posedge clk) begin
    if (exec && swr) s_mem[sd_i] <= res;
    if (exec && wwr) begin
      for (int i = 0; i < WB; i++)
        if (wmask[i]) w_mem[wd_i][i*WB +: WB] <= wdata[i*WB +: WB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pc_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      s_vld_r     <= '0;
      w_vld_r     <= '0;
    end else begin
      unique case (st_r)
        S_IDLE:  if (q_pop) st_r <= S_EXEC;
        S_EXEC:  st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      if (exec) begin
        pc_r        <= npc;
        out_valid_r <= 1'b1;
        if (ovf_set) ovf_r <= 1'b1;
        if (swr) s_vld_r[sd_i] <= 1'b1;
        if (wwr) w_vld_r[wd_i] <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_status_r <= ex_r.status;
      out_npc_r    <= 16'(npc);
      out_taken_r  <= taken;
      out_ovf_r    <= ovf_r | ovf_set;
      out_val_r    <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_next_pc      = out_npc_r;
  assign out_branch_taken = out_taken_r;
  assign out_overflow     = out_ovf_r;
  assign out_scalar_value = out_val_r;

endmodule

>>> hdl/wide_register_simd_execute_unit.sv
// ----------------------------------------------------------------------------
// wide_register_simd_execute_unit
// Scalar and wide-register instruction execute unit, one result per word.
// ----------------------------------------------------------------------------
// Decode checks each instruction word and drops it into a two-entry queue,
// so in_stall rises only when that queue is full. Execute pulls one word at a
// time: the pop captures its operands from the scalar and wide register
// files (registered read ports), then the execute state computes, writes back
// and loads the result register. A new word is not taken until the last one
// has left the execute state; a stalled result holds in the output register
// while decode keeps filling the queue.
module wide_register_simd_execute_unit #(
  parameter int WORD_BITS       = wrse_pkg::WORD_BITS_DEF,
  parameter int NUM_SCALAR_REGS = wrse_pkg::NUM_SCALAR_DEF,
  parameter int NUM_WIDE_REGS   = wrse_pkg::NUM_WIDE_DEF,
  parameter int PC_BITS         = wrse_pkg::PC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_kind,
  input  logic [5:0]         in_dest,
  input  logic [5:0]         in_src_a,
  input  logic [5:0]         in_src_b,
  input  logic signed [15:0] in_imm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [15:0]        out_next_pc,
  output logic               out_branch_taken,
  output logic               out_overflow,
  output logic signed [31:0] out_scalar_value
);

  wrse_pkg::op_t dec_op, head_op;
  logic          q_full, q_not_empty, q_pop;

  assign in_stall = q_full;

  wrse_front #(
    .WORD_BITS       (WORD_BITS),
    .NUM_SCALAR_REGS (NUM_SCALAR_REGS),
    .NUM_WIDE_REGS   (NUM_WIDE_REGS)
  ) u_front (
    .kind  (in_kind),
    .dest  (in_dest),
    .src_a (in_src_a),
    .src_b (in_src_b),
    .imm   (in_imm),
    .op    (dec_op)
  );

  wrse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_op   (dec_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  wrse_back #(
    .WORD_BITS       (WORD_BITS),
    .NUM_SCALAR_REGS (NUM_SCALAR_REGS),
    .NUM_WIDE_REGS   (NUM_WIDE_REGS),
    .PC_BITS         (PC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_op             (head_op),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_next_pc      (out_next_pc),
    .out_branch_taken (out_branch_taken),
    .out_overflow     (out_overflow),
    .out_scalar_value (out_scalar_value)
  );

endmodule

>>> hdl/wrse_checker.sv
// ----------------------------------------------------------------------------
// wrse_checker
// Port-level checks on the result channel of the execute unit.
// ----------------------------------------------------------------------------
module wrse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic               out_branch_taken,
  input logic               out_overflow,
  input logic signed [31:0] out_scalar_value
);

  logic seen_ovf_r;

  // remember an overflow once it has been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) seen_ovf_r <= 1'b0;
    else if (out_valid && !out_stall && out_overflow) seen_ovf_r <= 1'b1;
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scalar_value))
    else $error("stalled result dropped or changed");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != wrse_pkg::ST_OK |-> !out_branch_taken && out_scalar_value == '0)
    else $error("faulted word redirected or wrote a value");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= wrse_pkg::ST_BAD_STRIDE)
    else $error("status code out of range");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_ovf_r |-> out_overflow)
    else $error("overflow flag cleared");

endmodule

bind wide_register_simd_execute_unit wrse_checker u_wrse_checker (.*);
